// ===== hdl/tick_driven_calendar_clock_top_defines.svh =====
// Assertion macros for the calendar clock checker.
// Each macro expects signals named clock and reset in the using scope.
`ifndef TICK_DRIVEN_CALENDAR_CLOCK_TOP_DEFINES_SVH
`define TICK_DRIVEN_CALENDAR_CLOCK_TOP_DEFINES_SVH

// Same-cycle implication.
`define TDCC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TDCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tdcc_pkg.sv =====
package tdcc_pkg;

   localparam int KIND_W = 2;
   localparam int SUB_W  = 7;
   localparam int SEC_W  = 6;
   localparam int MIN_W  = 6;
   localparam int HOUR_W = 5;
   localparam int DAY_W  = 5;
   localparam int MON_W  = 4;
   localparam int YEAR_W = 16;
   localparam int CNT_W  = 32;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START = 2'd2;

   localparam logic [SUB_W-1:0]  SUB_LAST   = 7'd127;
   localparam logic [SEC_W-1:0]  SEC_LAST   = 6'd59;
   localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
   localparam logic [HOUR_W-1:0] HOUR_LAST  = 5'd23;
   localparam logic [MON_W-1:0]  MONTH_LAST = 4'd12;

   localparam logic [DAY_W-1:0]  DAY_FIRST   = 5'd1;
   localparam logic [MON_W-1:0]  MONTH_FIRST = 4'd1;
   localparam logic [YEAR_W-1:0] YEAR_RESET  = 16'd2000;

   localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MON_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MON_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MON_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MON_W-1:0] MONTH_NOV = 4'd11;

   // pulse flags carried with each result
   typedef struct packed {
      logic day;
      logic hour;
      logic minute;
      logic second;
   } pulse_type;

   // days in a month; unknown month codes count as 31
   function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] days;
      case (month) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = 5'd30;
         MONTH_FEB: days = leap ? 5'd29 : 5'd28;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

// ===== hdl/tick_driven_calendar_clock_top.sv =====
// Tick-driven real-time clock and calendar, 128 ticks per second.
//
// Request channel (req_*): one item per transfer. req_kind selects a tick,
// a calendar load (req_load_* fields) or a start, which clears the
// sub-second count and the since-start tick counter.
// Response channel (rsp_*): exactly one result per request, in order: the
// calendar after the item, one-shot second/minute/hour/day pulses (set only
// by the tick that completes the unit) and two wrapping 32-bit tick counts.
//
// The calendar registers are the result register, so a request's result is
// registered and shows from the cycle after the request transfers.
// Throughput is one item per cycle while the receiver keeps rsp_ready high;
// a new request is taken in the same cycle that the pending result transfers out.
// When the receiver stalls, the held result stays put and req_ready drops
// until that result transfers.
// Reset (synchronous, active high) sets 00:00:00 on day 1, month 1, year
// 2000, clears both tick counters and the pulses, and empties the result.
// The leap-year flag trails the year register via registers quot_ff/year_ff, then leap_ff;
// a day rollover needs at least 128 ticks after any year change, so it never sees it stale.
module tick_driven_calendar_clock_top (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [tdcc_pkg::KIND_W-1:0]  req_kind,
   input  logic [tdcc_pkg::SEC_W-1:0]   req_load_second,
   input  logic [tdcc_pkg::MIN_W-1:0]   req_load_minute,
   input  logic [tdcc_pkg::HOUR_W-1:0]  req_load_hour,
   input  logic [tdcc_pkg::DAY_W-1:0]   req_load_day,
   input  logic [tdcc_pkg::MON_W-1:0]   req_load_month,
   input  logic [tdcc_pkg::YEAR_W-1:0]  req_load_year,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tdcc_pkg::SEC_W-1:0]   rsp_cur_second,
   output logic [tdcc_pkg::MIN_W-1:0]   rsp_cur_minute,
   output logic [tdcc_pkg::HOUR_W-1:0]  rsp_cur_hour,
   output logic [tdcc_pkg::DAY_W-1:0]   rsp_cur_day,
   output logic [tdcc_pkg::MON_W-1:0]   rsp_cur_month,
   output logic [tdcc_pkg::YEAR_W-1:0]  rsp_cur_year,
   output logic                         rsp_second_pulse,
   output logic                         rsp_minute_pulse,
   output logic                         rsp_hour_pulse,
   output logic                         rsp_day_pulse,
   output logic [tdcc_pkg::CNT_W-1:0]   rsp_ticks_since_start,
   output logic [tdcc_pkg::CNT_W-1:0]   rsp_total_ticks
);

   logic                         accept;
   logic                         rsp_valid_ff, rsp_valid_in;

   // calendar and counter state, doubling as the result register
   logic [tdcc_pkg::SUB_W-1:0]   sub_ff,   sub_in;
   logic [tdcc_pkg::SEC_W-1:0]   sec_ff,   sec_in;
   logic [tdcc_pkg::MIN_W-1:0]   min_ff,   min_in;
   logic [tdcc_pkg::HOUR_W-1:0]  hour_ff,  hour_in;
   logic [tdcc_pkg::DAY_W-1:0]   day_ff,   day_in;
   logic [tdcc_pkg::MON_W-1:0]   month_ff, month_in;
   logic [tdcc_pkg::YEAR_W-1:0]  year_ff,  year_in;
   logic [tdcc_pkg::CNT_W-1:0]   start_ff, start_in;
   logic [tdcc_pkg::CNT_W-1:0]   run_ff,   run_in;
   tdcc_pkg::pulse_type          pulse_ff, pulse_in;

   logic                         leap;
   logic [tdcc_pkg::DAY_W-1:0]   mdays;

   tdcc_leap u_leap (
      .clock (clock),
      .year  (year_ff),
      .leap  (leap)
   );

   assign mdays = tdcc_pkg::month_days(month_ff, leap);

   // a pending result may leave in the same cycle a new item arrives
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // next state for the item at the input
   always_comb begin
      sub_in   = sub_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      start_in = start_ff;
      run_in   = run_ff;
      pulse_in = '0;

      unique case (req_kind)
         tdcc_pkg::KIND_TICK: begin
            start_in = start_ff + 1'b1;
            run_in   = run_ff + 1'b1;
            sub_in   = sub_ff + 1'b1;
            if (sub_ff == tdcc_pkg::SUB_LAST) begin
               pulse_in.second = 1'b1;
               if (sec_ff >= tdcc_pkg::SEC_LAST) begin
                  sec_in = '0;
                  pulse_in.minute = 1'b1;
                  if (min_ff >= tdcc_pkg::MIN_LAST) begin
                     min_in = '0;
                     pulse_in.hour = 1'b1;
                     if (hour_ff >= tdcc_pkg::HOUR_LAST) begin
                        hour_in = '0;
                        pulse_in.day = 1'b1;
                        // day rollover; past-end days start the next month
                        if (day_ff >= mdays) begin
                           day_in = tdcc_pkg::DAY_FIRST;
                           if (month_ff >= tdcc_pkg::MONTH_LAST) begin
                              month_in = tdcc_pkg::MONTH_FIRST;
                              year_in  = year_ff + 1'b1;
                           end else begin
                              month_in = month_ff + 1'b1;
                           end
                        end else begin
                           day_in = day_ff + 1'b1;
                        end
                     end else begin
                        hour_in = hour_ff + 1'b1;
                     end
                  end else begin
                     min_in = min_ff + 1'b1;
                  end
               end else begin
                  sec_in = sec_ff + 1'b1;
               end
            end
         end
         tdcc_pkg::KIND_LOAD: begin
            sec_in   = req_load_second;
            min_in   = req_load_minute;
            hour_in  = req_load_hour;
            day_in   = req_load_day;
            month_in = req_load_month;
            year_in  = req_load_year;
            sub_in   = '0;
         end
         tdcc_pkg::KIND_START: begin
            sub_in   = '0;
            start_in = '0;
         end
         default: begin
            // unused kind: state kept, pulses low
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= '0;
         sec_ff       <= '0;
         min_ff       <= '0;
         hour_ff      <= '0;
         day_ff       <= tdcc_pkg::DAY_FIRST;
         month_ff     <= tdcc_pkg::MONTH_FIRST;
         year_ff      <= tdcc_pkg::YEAR_RESET;
         start_ff     <= '0;
         run_ff       <= '0;
         pulse_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            sub_ff   <= sub_in;
            sec_ff   <= sec_in;
            min_ff   <= min_in;
            hour_ff  <= hour_in;
            day_ff   <= day_in;
            month_ff <= month_in;
            year_ff  <= year_in;
            start_ff <= start_in;
            run_ff   <= run_in;
            pulse_ff <= pulse_in;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_cur_second        = sec_ff;
   assign rsp_cur_minute        = min_ff;
   assign rsp_cur_hour          = hour_ff;
   assign rsp_cur_day           = day_ff;
   assign rsp_cur_month         = month_ff;
   assign rsp_cur_year          = year_ff;
   assign rsp_second_pulse      = pulse_ff.second;
   assign rsp_minute_pulse      = pulse_ff.minute;
   assign rsp_hour_pulse        = pulse_ff.hour;
   assign rsp_day_pulse         = pulse_ff.day;
   assign rsp_ticks_since_start = start_ff;
   assign rsp_total_ticks       = run_ff;

endmodule

// ===== hdl/tdcc_leap.sv =====
// Leap-year flag for the current year, registered via quot_ff/year_ff, then leap_ff.
// div by 100 = div4 & div25, div by 400 = div16 & div25.
module tdcc_leap (
   input  logic                       clock,
   input  logic [tdcc_pkg::YEAR_W-1:0] year,
   output logic                       leap
);

   // ceil(2^17 / 25): quotient is exact for every 16-bit multiple of 25,
   // and may run one high otherwise, which the compare below still rejects
   localparam int RECIP_W = 13;
   localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
   localparam int PROD_W  = tdcc_pkg::YEAR_W + RECIP_W;
   localparam int QUOT_W  = 12;

   logic [PROD_W-1:0]          prod;
   logic [QUOT_W-1:0]          quot_in, quot_ff;
   logic [tdcc_pkg::YEAR_W-1:0] year_ff;
   logic [QUOT_W+4:0]          back;
   logic                       div4, div16, div25;
   logic                       leap_in, leap_ff;

   assign prod    = PROD_W'(year) * PROD_W'(RECIP_25);
   assign quot_in = prod[PROD_W-1 -: QUOT_W];

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      year_ff <= year;
      leap_ff <= leap_in;
   end

   // quotient times 25 as shifts and adds
   assign back  = ({5'd0, quot_ff} << 4) + ({5'd0, quot_ff} << 3) + {5'd0, quot_ff};
   assign div25 = (back == {1'b0, year_ff});
   assign div4  = (year_ff[1:0] == 2'd0);
   assign div16 = (year_ff[3:0] == 4'd0);

   assign leap_in = div4 && (!div25 || div16);
   assign leap    = leap_ff;

endmodule

// ===== hdl/tdcc_checker.sv =====
`include "tick_driven_calendar_clock_top_defines.svh"

module tdcc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tdcc_pkg::SEC_W-1:0]   rsp_cur_second,
   input logic [tdcc_pkg::MIN_W-1:0]   rsp_cur_minute,
   input logic [tdcc_pkg::HOUR_W-1:0]  rsp_cur_hour,
   input logic                         rsp_second_pulse,
   input logic                         rsp_minute_pulse,
   input logic                         rsp_hour_pulse,
   input logic                         rsp_day_pulse,
   input logic [tdcc_pkg::CNT_W-1:0]   rsp_total_ticks
);

   // every transfer in shows its result on the next cycle
   `TDCC_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid, "result missing after request")

   // an empty result slot never blocks the request side
   `TDCC_ASSERT_IMPLY(a_ready_when_empty, !rsp_valid, req_ready, "request stalled with no result held")

   // carries nest: the minute and day pulses need the finer pulses and wrapped fields
   `TDCC_ASSERT_IMPLY(a_minute_nest, rsp_valid && rsp_minute_pulse, rsp_second_pulse && (rsp_cur_second == '0), "minute pulse without second wrap")

   `TDCC_ASSERT_IMPLY(a_day_nest, rsp_valid && rsp_day_pulse, rsp_hour_pulse && rsp_minute_pulse && (rsp_cur_hour == '0) && (rsp_cur_minute == '0), "day pulse without hour wrap")

   // held result stays put while stalled
   `TDCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_total_ticks) && $stable(rsp_cur_second), "stalled result changed")

endmodule

bind tick_driven_calendar_clock_top tdcc_checker u_tdcc_checker (.*);
